// ===== rtl/barycentric_coords_projected_assert.svh =====
// Assertion macros shared by the barycentric weight RTL.
// Needs signals named clock and reset in the scope of each use.
`ifndef BARYCENTRIC_COORDS_PROJECTED_ASSERT_SVH
`define BARYCENTRIC_COORDS_PROJECTED_ASSERT_SVH
`ifndef ASSERT_OFF
`define BCP_ASSERT(name, prop) \
   name: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("bcp: assertion failed");
`define BCP_ASSERT_ALWAYS(name, prop) \
   name: assert property (@(posedge clock) prop) \
      else $error("bcp: assertion failed");
`else
`define BCP_ASSERT(name, prop)
`define BCP_ASSERT_ALWAYS(name, prop)
`endif
`endif

// ===== rtl/bcp_pkg.sv =====
// Package for the barycentric weight block: widths, types and constants.
// Used by bcp_mul, bcp_div and barycentric_coords_projected; depends on nothing.
package bcp_pkg;

   localparam int COORD_WIDTH      = 32;
   localparam int WEIGHT_FRAC_BITS = 24;
   localparam int WEIGHT_WIDTH     = 32;
   localparam int LANES            = 3;

   localparam int SHIFT_WIDTH = COORD_WIDTH + 1;
   localparam int XPROD_WIDTH = 2 * SHIFT_WIDTH;
   localparam int CROSS_WIDTH = XPROD_WIDTH + 1;
   localparam int NORM_WIDTH  = CROSS_WIDTH + 2;
   localparam int LIMB_WIDTH  = (NORM_WIDTH + 2) / 3;
   localparam int MUL_WIDTH   = 3 * LIMB_WIDTH;
   localparam int PROD_WIDTH  = 2 * MUL_WIDTH;
   localparam int DOT_WIDTH   = PROD_WIDTH + 2;
   localparam int MAG_WIDTH   = DOT_WIDTH - 1;
   localparam int QUO_BITS    = WEIGHT_WIDTH;
   localparam int PRE_SHIFT   = QUO_BITS - WEIGHT_FRAC_BITS;

   typedef logic signed [COORD_WIDTH-1:0]  coord_type;
   typedef logic signed [SHIFT_WIDTH-1:0]  shift_type;
   typedef logic signed [XPROD_WIDTH-1:0]  xprod_type;
   typedef logic signed [CROSS_WIDTH-1:0]  cross_type;
   typedef logic signed [NORM_WIDTH-1:0]   norm_type;
   typedef logic signed [LIMB_WIDTH:0]     limb_type;
   typedef logic signed [2*LIMB_WIDTH+1:0] pp_type;
   typedef logic signed [MUL_WIDTH-1:0]    mul_op_type;
   typedef logic signed [PROD_WIDTH-1:0]   prod_type;
   typedef logic signed [DOT_WIDTH-1:0]    dot_type;
   typedef logic [MAG_WIDTH-1:0]           mag_type;
   typedef logic [QUO_BITS-1:0]            quo_type;
   typedef logic signed [WEIGHT_WIDTH-1:0] weight_type;

   // Rotation of three indices, used for the cross products
   localparam int ROT1 [3] = '{1, 2, 0};
   localparam int ROT2 [3] = '{2, 0, 1};

   localparam weight_type WEIGHT_ONE = weight_type'(1 << WEIGHT_FRAC_BITS);
   localparam weight_type WEIGHT_MAX = {1'b0, {(WEIGHT_WIDTH-1){1'b1}}};
   localparam weight_type WEIGHT_MIN = {1'b1, {(WEIGHT_WIDTH-1){1'b0}}};
   localparam logic [QUO_BITS:0] POS_LIMIT = {2'b00, {(QUO_BITS-1){1'b1}}};
   localparam logic [QUO_BITS:0] NEG_LIMIT = {2'b01, {(QUO_BITS-1){1'b0}}};

   typedef struct packed {
      logic    neg;
      mag_type mag;
   } lane_type;

   typedef struct packed {
      weight_type weight_a;
      weight_type weight_b;
      weight_type weight_c;
      logic       degenerate;
   } result_type;

endpackage

// ===== rtl/barycentric_coords_projected.sv =====
// Top level of the barycentric weight block: shift, cross products, normal,
// dot products, division and output buffering. Uses bcp_pkg, bcp_mul, bcp_div.
//
// Usage: one transaction on the req_ channel carries three triangle vertices
// and a query point, signed Q16.16. One transaction on the rsp_ channel
// returns the three barycentric weights of the point projected onto the
// triangle plane, signed Q7.24 rounded and saturated, plus a degenerate flag
// (zero normal: weights 1, 0, 0).
// A transaction is taken when valid is high and stall low at a clock edge.
// Throughput is one transaction per cycle while req_stall is low; the
// divider computes one quotient bit per stage over 32 stages.
// When the receiver stalls, the held result stays on rsp_ and one further
// result is parked in a skid register; only then does req_stall rise and
// the whole pipeline hold. Nothing in flight is lost or repeated.
// Reset (synchronous, active high) empties the pipeline and both output
// registers; there is no other state.
`include "barycentric_coords_projected_assert.svh"
module barycentric_coords_projected (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  bcp_pkg::coord_type  req_v1_x,
   input  bcp_pkg::coord_type  req_v1_y,
   input  bcp_pkg::coord_type  req_v1_z,
   input  bcp_pkg::coord_type  req_v2_x,
   input  bcp_pkg::coord_type  req_v2_y,
   input  bcp_pkg::coord_type  req_v2_z,
   input  bcp_pkg::coord_type  req_v3_x,
   input  bcp_pkg::coord_type  req_v3_y,
   input  bcp_pkg::coord_type  req_v3_z,
   input  bcp_pkg::coord_type  req_query_x,
   input  bcp_pkg::coord_type  req_query_y,
   input  bcp_pkg::coord_type  req_query_z,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output bcp_pkg::weight_type rsp_weight_a,
   output bcp_pkg::weight_type rsp_weight_b,
   output bcp_pkg::weight_type rsp_weight_c,
   output logic                rsp_degenerate
);

   bcp_pkg::coord_type  vert [3][3];
   bcp_pkg::coord_type  qpt  [3];
   logic                en;
   logic                accept;

   bcp_pkg::shift_type  s_in   [3][3];
   bcp_pkg::shift_type  s_ff   [3][3];
   bcp_pkg::xprod_type  xp_in  [3][3][2];
   bcp_pkg::xprod_type  xp_ff  [3][3][2];
   bcp_pkg::cross_type  c_in   [3][3];
   bcp_pkg::cross_type  c_ff   [3][3];
   bcp_pkg::cross_type  cc_ff  [3][3];
   bcp_pkg::norm_type   n_in   [3];
   bcp_pkg::norm_type   n_ff   [3];
   bcp_pkg::prod_type   prod   [4][3];
   logic [11:0]         mul_valid;
   bcp_pkg::dot_type    den_in;
   bcp_pkg::dot_type    den_ff;
   bcp_pkg::dot_type    num_in [3];
   bcp_pkg::dot_type    num_ff [3];
   bcp_pkg::lane_type   lane_in [bcp_pkg::LANES];
   bcp_pkg::lane_type   lane_ff [bcp_pkg::LANES];
   bcp_pkg::dot_type    abs_den_ff;
   logic                degen_in;
   logic                degen_ff;

   logic s_valid_ff, xp_valid_ff, c_valid_ff, n_valid_ff, dot_valid_ff, abs_valid_ff;

   logic                div_valid;
   bcp_pkg::result_type div_result;
   logic                rsp_valid_in, rsp_valid_ff;
   logic                skid_valid_in, skid_valid_ff;
   bcp_pkg::result_type rsp_data_in, rsp_data_ff;
   bcp_pkg::result_type skid_data_in, skid_data_ff;

   assign vert[0][0] = req_v1_x;
   assign vert[0][1] = req_v1_y;
   assign vert[0][2] = req_v1_z;
   assign vert[1][0] = req_v2_x;
   assign vert[1][1] = req_v2_y;
   assign vert[1][2] = req_v2_z;
   assign vert[2][0] = req_v3_x;
   assign vert[2][1] = req_v3_y;
   assign vert[2][2] = req_v3_z;
   assign qpt[0]     = req_query_x;
   assign qpt[1]     = req_query_y;
   assign qpt[2]     = req_query_z;

   // the pipeline only holds once the skid register is occupied
   assign en        = !skid_valid_ff;
   assign req_stall = skid_valid_ff;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      bcp_pkg::shift_type a1, a2, b1, b2;
      for (int v = 0; v < 3; v++) begin
         for (int k = 0; k < 3; k++) begin
            s_in[v][k] = bcp_pkg::shift_type'(vert[v][k])
                       - bcp_pkg::shift_type'(qpt[k]);
         end
      end
      // groups: s2 x s3, s3 x s1, s1 x s2
      for (int g = 0; g < 3; g++) begin
         for (int k = 0; k < 3; k++) begin
            a1 = s_ff[bcp_pkg::ROT1[g]][bcp_pkg::ROT1[k]];
            a2 = s_ff[bcp_pkg::ROT1[g]][bcp_pkg::ROT2[k]];
            b1 = s_ff[bcp_pkg::ROT2[g]][bcp_pkg::ROT1[k]];
            b2 = s_ff[bcp_pkg::ROT2[g]][bcp_pkg::ROT2[k]];
            xp_in[g][k][0] = a1 * b2;
            xp_in[g][k][1] = a2 * b1;
            c_in[g][k] = bcp_pkg::cross_type'(xp_ff[g][k][0])
                       - bcp_pkg::cross_type'(xp_ff[g][k][1]);
         end
      end
      for (int k = 0; k < 3; k++) begin
         n_in[k] = bcp_pkg::norm_type'(c_ff[0][k]) + bcp_pkg::norm_type'(c_ff[1][k])
                 + bcp_pkg::norm_type'(c_ff[2][k]);
      end
   end

   for (genvar g = 0; g < 4; g++) begin : g_grp
      for (genvar k = 0; k < 3; k++) begin : g_comp
         bcp_pkg::mul_op_type op_a;
         bcp_pkg::mul_op_type op_b;
         assign op_a = bcp_pkg::mul_op_type'(n_ff[k]);
         if (g == 0) begin : g_den
            assign op_b = bcp_pkg::mul_op_type'(n_ff[k]);
         end else begin : g_num
            assign op_b = bcp_pkg::mul_op_type'(cc_ff[g-1][k]);
         end
         bcp_mul u_mul (
            .clock     (clock),
            .reset     (reset),
            .en        (en),
            .in_valid  (n_valid_ff),
            .in_a      (op_a),
            .in_b      (op_b),
            .out_valid (mul_valid[g*3+k]),
            .out_prod  (prod[g][k])
         );
      end
   end

   always_comb begin
      bcp_pkg::dot_type mag_full;
      den_in = bcp_pkg::dot_type'(prod[0][0]) + bcp_pkg::dot_type'(prod[0][1])
             + bcp_pkg::dot_type'(prod[0][2]);
      for (int l = 0; l < 3; l++) begin
         num_in[l] = bcp_pkg::dot_type'(prod[l+1][0]) + bcp_pkg::dot_type'(prod[l+1][1])
                   + bcp_pkg::dot_type'(prod[l+1][2]);
      end
      for (int l = 0; l < bcp_pkg::LANES; l++) begin
         lane_in[l].neg = num_ff[l][bcp_pkg::DOT_WIDTH-1];
         mag_full       = num_ff[l][bcp_pkg::DOT_WIDTH-1] ? -num_ff[l] : num_ff[l];
         lane_in[l].mag = mag_full[bcp_pkg::MAG_WIDTH-1:0];
      end
      degen_in = den_ff == '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s_valid_ff   <= 1'b0;
         xp_valid_ff  <= 1'b0;
         c_valid_ff   <= 1'b0;
         n_valid_ff   <= 1'b0;
         dot_valid_ff <= 1'b0;
         abs_valid_ff <= 1'b0;
      end else if (en) begin
         s_valid_ff   <= accept;
         xp_valid_ff  <= s_valid_ff;
         c_valid_ff   <= xp_valid_ff;
         n_valid_ff   <= c_valid_ff;
         dot_valid_ff <= &mul_valid;
         abs_valid_ff <= dot_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s_ff       <= s_in;
         xp_ff      <= xp_in;
         c_ff       <= c_in;
         cc_ff      <= c_ff;
         n_ff       <= n_in;
         den_ff     <= den_in;
         num_ff     <= num_in;
         lane_ff    <= lane_in;
         abs_den_ff <= den_ff;
         degen_ff   <= degen_in;
      end
   end

   bcp_div u_div (
      .clock      (clock),
      .reset      (reset),
      .en         (en),
      .in_valid   (abs_valid_ff),
      .in_den     (abs_den_ff),
      .in_degen   (degen_ff),
      .in_lane    (lane_ff),
      .out_valid  (div_valid),
      .out_result (div_result)
   );

   // output register with one skid entry behind it
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (!rsp_valid_ff || !rsp_stall) begin
         if (skid_valid_ff) begin
            rsp_valid_in  = 1'b1;
            rsp_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            rsp_valid_in = div_valid;
            rsp_data_in  = div_result;
         end
      end else if (div_valid && en) begin
         skid_valid_in = 1'b1;
         skid_data_in  = div_result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff  <= rsp_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_weight_a   = rsp_data_ff.weight_a;
   assign rsp_weight_b   = rsp_data_ff.weight_b;
   assign rsp_weight_c   = rsp_data_ff.weight_c;
   assign rsp_degenerate = rsp_data_ff.degenerate;

   `BCP_ASSERT(a_skid_behind_rsp, skid_valid_ff |-> rsp_valid_ff)
   `BCP_ASSERT(a_skid_drains, rsp_valid_ff && !rsp_stall && skid_valid_ff |=> rsp_valid_ff && !skid_valid_ff)
   `BCP_ASSERT(a_degen_weights, rsp_valid && rsp_degenerate |-> rsp_weight_b == '0 && rsp_weight_c == '0)

endmodule

// ===== rtl/bcp_mul.sv =====
// Three-stage signed multiplier built from 3x3 limb partial products.
// Depends on bcp_pkg.
module bcp_mul (
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  logic                in_valid,
   input  bcp_pkg::mul_op_type in_a,
   input  bcp_pkg::mul_op_type in_b,
   output logic                out_valid,
   output bcp_pkg::prod_type   out_prod
);

   bcp_pkg::pp_type   pp_in  [3][3];
   bcp_pkg::pp_type   pp_ff  [3][3];
   bcp_pkg::prod_type row_in [3];
   bcp_pkg::prod_type row_ff [3];
   bcp_pkg::prod_type prod_in;
   bcp_pkg::prod_type prod_ff;
   logic [2:0]        valid_ff;

   always_comb begin
      bcp_pkg::limb_type la [3];
      bcp_pkg::limb_type lb [3];
      // lower limbs are unsigned, the top limb carries the sign
      for (int i = 0; i < 2; i++) begin
         la[i] = {1'b0, in_a[i*bcp_pkg::LIMB_WIDTH +: bcp_pkg::LIMB_WIDTH]};
         lb[i] = {1'b0, in_b[i*bcp_pkg::LIMB_WIDTH +: bcp_pkg::LIMB_WIDTH]};
      end
      la[2] = {in_a[bcp_pkg::MUL_WIDTH-1],
               in_a[2*bcp_pkg::LIMB_WIDTH +: bcp_pkg::LIMB_WIDTH]};
      lb[2] = {in_b[bcp_pkg::MUL_WIDTH-1],
               in_b[2*bcp_pkg::LIMB_WIDTH +: bcp_pkg::LIMB_WIDTH]};
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            pp_in[i][j] = la[i] * lb[j];
         end
      end
      for (int i = 0; i < 3; i++) begin
         row_in[i] = bcp_pkg::prod_type'(pp_ff[i][0])
                   + (bcp_pkg::prod_type'(pp_ff[i][1]) << bcp_pkg::LIMB_WIDTH)
                   + (bcp_pkg::prod_type'(pp_ff[i][2]) << (2*bcp_pkg::LIMB_WIDTH));
      end
      prod_in = row_ff[0]
              + (row_ff[1] << bcp_pkg::LIMB_WIDTH)
              + (row_ff[2] << (2*bcp_pkg::LIMB_WIDTH));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[1:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pp_ff   <= pp_in;
         row_ff  <= row_in;
         prod_ff <= prod_in;
      end
   end

   assign out_valid = valid_ff[2];
   assign out_prod  = prod_ff;

endmodule

// ===== rtl/bcp_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, three lanes sharing
// one divisor; rounds, saturates and applies the degenerate fallback. Uses bcp_pkg.
`include "barycentric_coords_projected_assert.svh"
module bcp_div (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  logic                 in_valid,
   input  bcp_pkg::dot_type     in_den,
   input  logic                 in_degen,
   input  bcp_pkg::lane_type    in_lane [bcp_pkg::LANES],
   output logic                 out_valid,
   output bcp_pkg::result_type  out_result
);

   localparam int NS = bcp_pkg::QUO_BITS + 1;

   logic [bcp_pkg::DOT_WIDTH-1:0] rem_in  [NS][bcp_pkg::LANES];
   logic [bcp_pkg::DOT_WIDTH-1:0] rem_ff  [NS][bcp_pkg::LANES];
   bcp_pkg::quo_type              quo_in  [NS][bcp_pkg::LANES];
   bcp_pkg::quo_type              quo_ff  [NS][bcp_pkg::LANES];
   bcp_pkg::quo_type              low_in  [NS][bcp_pkg::LANES];
   bcp_pkg::quo_type              low_ff  [NS][bcp_pkg::LANES];
   logic                          neg_in  [NS][bcp_pkg::LANES];
   logic                          neg_ff  [NS][bcp_pkg::LANES];
   logic                          sat_in  [NS][bcp_pkg::LANES];
   logic                          sat_ff  [NS][bcp_pkg::LANES];
   logic [bcp_pkg::DOT_WIDTH-1:0] den_in  [NS];
   logic [bcp_pkg::DOT_WIDTH-1:0] den_ff  [NS];
   logic [NS-1:0]                 degen_in;
   logic [NS-1:0]                 degen_ff;
   logic [NS-1:0]                 valid_ff;
   logic                          out_valid_ff;
   bcp_pkg::result_type           result_in;
   bcp_pkg::result_type           result_ff;

   always_comb begin
      logic [bcp_pkg::DOT_WIDTH:0]   trial;
      logic [bcp_pkg::DOT_WIDTH:0]   diff;
      logic [bcp_pkg::DOT_WIDTH:0]   den_ext;
      logic [bcp_pkg::DOT_WIDTH:0]   rem_dbl;
      logic [bcp_pkg::DOT_WIDTH-1:0] top_part;
      logic [bcp_pkg::QUO_BITS:0]    q_rnd;
      logic [bcp_pkg::QUO_BITS:0]    q_neg;
      logic                          rnd_up;
      bcp_pkg::weight_type           w [bcp_pkg::LANES];

      // entry: the quotient must fit, else the lane saturates
      den_in[0]   = in_den;
      degen_in[0] = in_degen;
      for (int l = 0; l < bcp_pkg::LANES; l++) begin
         top_part     = {1'b0, in_lane[l].mag} >> bcp_pkg::PRE_SHIFT;
         rem_in[0][l] = top_part;
         sat_in[0][l] = top_part >= in_den;
         neg_in[0][l] = in_lane[l].neg;
         quo_in[0][l] = '0;
         low_in[0][l] = {in_lane[l].mag[bcp_pkg::PRE_SHIFT-1:0],
                         {bcp_pkg::WEIGHT_FRAC_BITS{1'b0}}};
      end

      for (int k = 0; k < bcp_pkg::QUO_BITS; k++) begin
         den_in[k+1]   = den_ff[k];
         degen_in[k+1] = degen_ff[k];
         den_ext       = {1'b0, den_ff[k]};
         for (int l = 0; l < bcp_pkg::LANES; l++) begin
            trial = {rem_ff[k][l], low_ff[k][l][bcp_pkg::QUO_BITS-1]};
            diff  = trial - den_ext;
            if (trial >= den_ext) begin
               rem_in[k+1][l] = diff[bcp_pkg::DOT_WIDTH-1:0];
               quo_in[k+1][l] = {quo_ff[k][l][bcp_pkg::QUO_BITS-2:0], 1'b1};
            end else begin
               rem_in[k+1][l] = trial[bcp_pkg::DOT_WIDTH-1:0];
               quo_in[k+1][l] = {quo_ff[k][l][bcp_pkg::QUO_BITS-2:0], 1'b0};
            end
            low_in[k+1][l] = {low_ff[k][l][bcp_pkg::QUO_BITS-2:0], 1'b0};
            neg_in[k+1][l] = neg_ff[k][l];
            sat_in[k+1][l] = sat_ff[k][l];
         end
      end

      // round half away from zero, then clamp
      den_ext = {1'b0, den_ff[bcp_pkg::QUO_BITS]};
      for (int l = 0; l < bcp_pkg::LANES; l++) begin
         rem_dbl = {rem_ff[bcp_pkg::QUO_BITS][l], 1'b0};
         rnd_up  = rem_dbl >= den_ext;
         q_rnd   = {1'b0, quo_ff[bcp_pkg::QUO_BITS][l]}
                 + {{bcp_pkg::QUO_BITS{1'b0}}, rnd_up};
         q_neg   = '0 - q_rnd;
         if (neg_ff[bcp_pkg::QUO_BITS][l]) begin
            if (sat_ff[bcp_pkg::QUO_BITS][l] || q_rnd > bcp_pkg::NEG_LIMIT) begin
               w[l] = bcp_pkg::WEIGHT_MIN;
            end else begin
               w[l] = q_neg[bcp_pkg::QUO_BITS-1:0];
            end
         end else begin
            if (sat_ff[bcp_pkg::QUO_BITS][l] || q_rnd > bcp_pkg::POS_LIMIT) begin
               w[l] = bcp_pkg::WEIGHT_MAX;
            end else begin
               w[l] = q_rnd[bcp_pkg::QUO_BITS-1:0];
            end
         end
      end

      if (degen_ff[bcp_pkg::QUO_BITS]) begin
         result_in.weight_a   = bcp_pkg::WEIGHT_ONE;
         result_in.weight_b   = '0;
         result_in.weight_c   = '0;
         result_in.degenerate = 1'b1;
      end else begin
         result_in.weight_a   = w[0];
         result_in.weight_b   = w[1];
         result_in.weight_c   = w[2];
         result_in.degenerate = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff     <= {valid_ff[NS-2:0], in_valid};
         out_valid_ff <= valid_ff[NS-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff    <= rem_in;
         quo_ff    <= quo_in;
         low_ff    <= low_in;
         neg_ff    <= neg_in;
         sat_ff    <= sat_in;
         den_ff    <= den_in;
         degen_ff  <= degen_in;
         result_ff <= result_in;
      end
   end

   assign out_valid  = out_valid_ff;
   assign out_result = result_ff;

   `BCP_ASSERT(a_div_valid_moves, en |=> valid_ff[NS-1] == $past(valid_ff[NS-2]))
   `BCP_ASSERT(a_div_frozen, !en |=> $stable(valid_ff) && $stable(out_valid_ff))
   `BCP_ASSERT(a_div_rem_below_den, valid_ff[NS-1] && !degen_ff[NS-1] && !sat_ff[NS-1][0] |-> rem_ff[NS-1][0] < den_ff[NS-1])
   `BCP_ASSERT_ALWAYS(a_div_reset_clears, reset |=> !out_valid_ff && valid_ff == '0)

endmodule

// ===== tb/barycentric_coords_projected_test.sv =====
// Testbench for barycentric_coords_projected: directed table, then random
// triangles, checked against an exact wide-integer predictor of the weights.
// Depends on bcp_pkg and the barycentric_coords_projected RTL.
module barycentric_coords_projected_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RANDOM_ITEMS = 850;
   localparam int WATCHDOG     = 3000;
   localparam int HOLD_CYCLES  = 300;

   typedef logic signed [255:0] wide_type;

   typedef struct {
      bcp_pkg::coord_type  c [12];
      logic                typed;
      bcp_pkg::result_type want;
   } tri_item_type;

   logic                clock, reset;
   logic                req_valid, req_stall, rsp_valid, rsp_stall;
   bcp_pkg::coord_type  req_c [12];
   bcp_pkg::weight_type rsp_weight_a, rsp_weight_b, rsp_weight_c;
   logic                rsp_degenerate;

   tri_item_type        stim_q [$];
   tri_item_type        cur_item;
   bcp_pkg::result_type weights_due [$];
   int errors = 0, results_seen = 0, idle_count = 0;
   bit all_sent = 0;

   barycentric_coords_projected dut (
      .clock, .reset, .req_valid, .req_stall,
      .req_v1_x(req_c[0]), .req_v1_y(req_c[1]), .req_v1_z(req_c[2]),
      .req_v2_x(req_c[3]), .req_v2_y(req_c[4]), .req_v2_z(req_c[5]),
      .req_v3_x(req_c[6]), .req_v3_y(req_c[7]), .req_v3_z(req_c[8]),
      .req_query_x(req_c[9]), .req_query_y(req_c[10]), .req_query_z(req_c[11]),
      .rsp_valid, .rsp_stall, .rsp_weight_a, .rsp_weight_b, .rsp_weight_c,
      .rsp_degenerate
   );

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   function automatic void cross3(input wide_type a [3], input wide_type b [3],
                                  output wide_type o [3]);
      o[0] = a[1] * b[2] - a[2] * b[1];
      o[1] = a[2] * b[0] - a[0] * b[2];
      o[2] = a[0] * b[1] - a[1] * b[0];
   endfunction

   function automatic wide_type dot3(input wide_type a [3], input wide_type b [3]);
      return a[0] * b[0] + a[1] * b[1] + a[2] * b[2];
   endfunction

   // Round half away from zero, then clamp to the 32-bit range
   function automatic bcp_pkg::weight_type ratio_to_weight(wide_type num, wide_type den);
      wide_type mag, q, r;
      logic neg;
      neg = num < 0;
      mag = neg ? -num : num;
      q = (mag <<< bcp_pkg::WEIGHT_FRAC_BITS) / den;
      r = (mag <<< bcp_pkg::WEIGHT_FRAC_BITS) % den;
      if ((r <<< 1) >= den) q = q + 1;
      if (neg) return (q > (wide_type'(1) <<< 31)) ? bcp_pkg::WEIGHT_MIN
                                                   : bcp_pkg::weight_type'(-q);
      return (q > wide_type'(32'h7FFFFFFF)) ? bcp_pkg::WEIGHT_MAX
                                            : bcp_pkg::weight_type'(q);
   endfunction

   function automatic bcp_pkg::result_type project_weights(tri_item_type t);
      wide_type s [3][3];
      wide_type a23 [3], a31 [3], a12 [3], nrm [3];
      wide_type den;
      bcp_pkg::result_type res;
      for (int v = 0; v < 3; v++)
         for (int k = 0; k < 3; k++)
            s[v][k] = wide_type'(t.c[v*3+k]) - wide_type'(t.c[9+k]);
      cross3(s[1], s[2], a23);
      cross3(s[2], s[0], a31);
      cross3(s[0], s[1], a12);
      for (int k = 0; k < 3; k++) nrm[k] = a12[k] + a23[k] + a31[k];
      den = dot3(nrm, nrm);
      if (den == 0) return '{bcp_pkg::WEIGHT_ONE, '0, '0, 1'b1};
      res.weight_a   = ratio_to_weight(dot3(nrm, a23), den);
      res.weight_b   = ratio_to_weight(dot3(nrm, a31), den);
      res.weight_c   = ratio_to_weight(dot3(nrm, a12), den);
      res.degenerate = 1'b0;
      return res;
   endfunction

   function automatic tri_item_type mk_row(bcp_pkg::coord_type c [12], logic typed,
                                           bcp_pkg::result_type want);
      tri_item_type t;
      t.c = c;
      t.typed = typed;
      t.want = want;
      return t;
   endfunction

   function automatic bcp_pkg::coord_type pick_extreme();
      case ($urandom_range(4))
         0: return 32'h80000000;
         1: return 32'h7FFFFFFF;
         2: return 32'hFFFFFFFF;
         3: return 32'h00000001;
         default: return '0;
      endcase
   endfunction

   function automatic tri_item_type random_row();
      tri_item_type t;
      int mode, span, k;
      bcp_pkg::coord_type base [3], d [3];
      mode = $urandom_range(9);
      span = 1 << $urandom_range(20, 4);
      for (int i = 0; i < 3; i++) begin
         base[i] = $urandom_range(2 * span) - span;
         d[i]    = $urandom_range(2 * span) - span;
      end
      for (int i = 0; i < 12; i++) begin
         case (mode)
            0, 1, 2: t.c[i] = $urandom;
            6:       t.c[i] = base[i % 3];
            8:       t.c[i] = pick_extreme();
            default: t.c[i] = base[i % 3] + $urandom_range(2 * span) - span;
         endcase
      end
      // collinear and coincident vertices give a zero normal
      if (mode == 6) begin
         k = $urandom_range(6) - 3;
         for (int i = 0; i < 3; i++) begin
            t.c[3+i] = base[i] + d[i];
            t.c[6+i] = base[i] + k * d[i];
            t.c[9+i] = $urandom;
         end
      end else if (mode == 7 && $urandom_range(1)) begin
         for (int i = 3; i < 9; i++) t.c[i] = t.c[i % 3];
      end
      t.typed = 1'b0;
      t.want = '0;
      return t;
   endfunction

   task automatic report_mismatch(string what, bcp_pkg::weight_type got,
                                  bcp_pkg::weight_type want);
      errors++;
      $display("mismatch %s: got %h, want %h", what, got, want);
   endtask

   // stimulus
   initial begin
      int unsigned ix;
      bit quiet;
      reset <= 1'b1;
      req_valid <= 1'b0;
      for (int i = 0; i < 12; i++) req_c[i] <= '0;
      // directed table: typed rows where the answer is plain, then untyped rows for the predictor
      stim_q.push_back(mk_row('{default: 0}, 1, '{bcp_pkg::WEIGHT_ONE, 0, 0, 1}));
      stim_q.push_back(mk_row('{default: 32'h7FFFFFFF}, 1,
                              '{bcp_pkg::WEIGHT_ONE, 0, 0, 1}));
      stim_q.push_back(mk_row('{default: 32'h80000000}, 1,
                              '{bcp_pkg::WEIGHT_ONE, 0, 0, 1}));
      stim_q.push_back(mk_row('{0, 0, 0, 32'h10000, 0, 0, 32'h20000, 0, 0, 5, 6, 7},
                              1, '{bcp_pkg::WEIGHT_ONE, 0, 0, 1}));
      stim_q.push_back(mk_row('{0, 0, 0, 32'h10000, 0, 0, 0, 32'h10000, 0, 0, 0, 0},
                              1, '{bcp_pkg::WEIGHT_ONE, 0, 0, 0}));
      stim_q.push_back(mk_row('{0, 0, 0, 32'h10000, 0, 0, 0, 32'h10000, 0,
                                32'h10000, 0, 32'h30000}, 1,
                              '{0, bcp_pkg::WEIGHT_ONE, 0, 0}));
      stim_q.push_back(mk_row('{0, 0, 0, 32'h10000, 0, 0, 0, 32'h10000, 0,
                                0, 32'h10000, 32'h80000000}, 1,
                              '{0, 0, bcp_pkg::WEIGHT_ONE, 0}));
      stim_q.push_back(mk_row('{0, 0, 0, 1, 0, 0, 0, 1, 0, 32'h7FFFFFFF, 0, 0},
                              1, '{bcp_pkg::WEIGHT_MIN, bcp_pkg::WEIGHT_MAX, 0, 0}));
      stim_q.push_back(mk_row('{0, 0, 0, 1, 0, 0, 0, 1, 0, 32'h80000000, 0, 0},
                              1, '{bcp_pkg::WEIGHT_MAX, bcp_pkg::WEIGHT_MIN, 0, 0}));
      stim_q.push_back(mk_row('{32'h80000000, 32'h80000000, 32'h80000000,
                                32'h7FFFFFFF, 32'h80000000, 32'h80000000,
                                32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF,
                                32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000}, 0, '0));
      stim_q.push_back(mk_row('{32'h7FFFFFFF, 0, 32'h80000000, 0, 32'h7FFFFFFF, 0,
                                32'h80000000, 32'h80000000, 32'h7FFFFFFF,
                                0, 0, 0}, 0, '0));
      stim_q.push_back(mk_row('{0, 0, 0, 32'h30000, 0, 0, 0, 32'h30000, 0,
                                32'h10000, 32'h10000, 32'h10000}, 0, '0));
      stim_q.push_back(mk_row('{0, 0, 0, 3, 0, 0, 0, 3, 0, 1, 1, 0}, 0, '0));
      stim_q.push_back(mk_row('{32'h10000, 32'h20000, 32'h30000, 32'hFFFF0000, 0,
                                32'h50000, 32'h7000, 32'hFFFFFFFF, 32'h1, 32'h12345,
                                32'hFEDCBA98, 32'h00ABCDEF}, 0, '0));
      for (int i = 0; i < RANDOM_ITEMS; i++) stim_q.push_back(random_row());
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      ix = 0;
      while (ix < stim_q.size() || (req_valid && req_stall)) begin
         @(posedge clock);
         if (req_valid && req_stall) continue;     // hold the stalled transaction
         quiet = (ix > 300 && ix < 500);
         if (ix == 650 && weights_due.size() != 0) begin
            req_valid <= 1'b0;                      // drain before going on
         end else if (ix < stim_q.size() && (quiet || $urandom_range(99) >= 37)) begin
            cur_item <= stim_q[ix];
            req_c <= stim_q[ix].c;
            req_valid <= 1'b1;
            ix++;
         end else begin
            req_valid <= 1'b0;
         end
      end
      @(posedge clock);
      while (req_valid && req_stall) @(posedge clock);
      req_valid <= 1'b0;
      all_sent = 1;
   end

   // receiver, with one long hold-off once 200 results have been seen
   initial begin
      int hold_left;
      bit held;
      hold_left = 0;
      held = 0;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (!held && results_seen >= 200) begin
            held = 1;
            hold_left = HOLD_CYCLES;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= (results_seen > 350 && results_seen < 550) ? 1'b0
                         : ($urandom_range(99) < 37);
         end
      end
   end

   // predict on accept, check on delivery
   always @(posedge clock) begin
      bcp_pkg::result_type want;
      logic moved;
      if (!reset) begin
         moved = 1'b0;
         if (req_valid && !req_stall) begin
            weights_due.push_back(cur_item.typed ? cur_item.want
                                                 : project_weights(cur_item));
            moved = 1'b1;
         end
         if (rsp_valid && !rsp_stall) begin
            moved = 1'b1;
            results_seen++;
            if (weights_due.size() == 0) begin
               errors++;
               $display("unexpected transaction on rsp_");
            end else begin
               want = weights_due.pop_front();
               if (rsp_weight_a !== want.weight_a)
                  report_mismatch("weight_a", rsp_weight_a, want.weight_a);
               if (rsp_weight_b !== want.weight_b)
                  report_mismatch("weight_b", rsp_weight_b, want.weight_b);
               if (rsp_weight_c !== want.weight_c)
                  report_mismatch("weight_c", rsp_weight_c, want.weight_c);
               if (rsp_degenerate !== want.degenerate)
                  report_mismatch("degenerate", bcp_pkg::weight_type'(rsp_degenerate),
                                  bcp_pkg::weight_type'(want.degenerate));
            end
         end
         idle_count <= moved ? 0 : idle_count + 1;
      end
   end

   initial begin
      wait (idle_count >= WATCHDOG);
      $display("timeout");
      $display("** barycentric_coords_projected: FAILED **");
      $finish;
   end

   initial begin
      wait (all_sent);
      while (weights_due.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (errors == 0) begin
         $display("** barycentric_coords_projected: PASSED **");
      end else begin
         $display("** barycentric_coords_projected: FAILED **");
      end
      $finish;
   end

endmodule
